// ===== sv/rmaml_pkg.sv =====
// Shared constants for the range max-at-most-limit query block.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package rmaml_pkg;

  localparam int IDX_W     = 10;
  localparam int LEN_W     = 11;
  localparam int LANES     = 16;
  localparam int LANE_W    = 4;
  localparam int TREE_LVLS = 4;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== sv/range_max_at_most_limit_top.sv =====
// Top level of the range max-at-most-limit query block.
// Depends on rmaml_pkg.
//
// Elements live in sixteen banks, so one read returns a row of sixteen consecutive entries.
// A write leaves the input ready for the next item. A query scans the rows that its range
// touches, one row per cycle through the banked read port, into a registered compare tree.
// The rows scanned are the 16-entry rows in the range: at most DEPTH/16, or 64 at the
// default depth. The input is ready again when the result is loaded. A query with a bad
// range scans nothing; its result is loaded from the drain state once the output register
// is free. The output register holds one result until it is taken, and the next item is
// accepted meanwhile; a query that ends while that result is still untaken waits for it
// before loading its own.
`timescale 1ns / 1ps
`default_nettype none

module range_max_at_most_limit_top
  import rmaml_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  input  wire                                         cfg_wr_en_i,
  input  wire  [LEN_W-1:0]                            cfg_wr_data_i,
  input  wire                                         s_axis_tvalid,
  output logic                                        s_axis_tready,
  // lo_index, hi_index, value; zero padded
  input  wire  [((2*IDX_W+VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // kind
  input  wire                                         s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  wire                                         m_axis_tready,
  // answer; zero padded
  output logic [((VALUE_BITS+1+7)/8)*8-1:0]           m_axis_tdata,
  // bad_range
  output logic                                        m_axis_tuser
);

  localparam int ROWS   = (DEPTH + LANES - 1) / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int OUT_W  = ((VALUE_BITS + 1 + 7) / 8) * 8;
  localparam int ANS_W  = VALUE_BITS + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e state_q;

  logic [LEN_W-1:0]      array_length_q;
  logic [IDX_W-1:0]      lo_q, hi_q;
  logic [VALUE_BITS-1:0] limit_q;
  logic [ROW_W-1:0]      row_q;
  logic                  bad_q;
  logic                  best_found_q;
  logic [VALUE_BITS-1:0] best_q;
  logic                  out_v_q;
  logic [ANS_W-1:0]      out_ans_q;
  logic                  out_bad_q;

  // input fields
  logic [IDX_W-1:0]      in_lo, in_hi;
  logic [VALUE_BITS-1:0] in_val;
  logic                  in_acc;
  logic                  in_bad;

  assign in_lo  = s_axis_tdata[IDX_W-1:0];
  assign in_hi  = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_val = s_axis_tdata[2*IDX_W+VALUE_BITS-1:2*IDX_W];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_bad = (in_lo > in_hi) || ({1'b0, in_hi} >= array_length_q) ||
                  (32'(in_hi) >= 32'(DEPTH));

  assign s_axis_tready = (state_q == ST_IDLE);

  // banked element store
  logic                  wr_en;
  logic [ROW_W-1:0]      wr_row;
  logic [LANE_W-1:0]     wr_lane;
  logic                  rd_en;
  logic [ROW_W-1:0]      lo_row, hi_row;
  logic [LANES-1:0]      rd_mask;
  logic [VALUE_BITS-1:0] rd_data_q [LANES];
  logic                  rd_v_q;
  logic [LANES-1:0]      rd_mask_q;

  assign wr_en   = in_acc && (s_axis_tuser == KIND_WRITE) && (32'(in_lo) < 32'(DEPTH));
  assign wr_row  = ROW_W'(in_lo >> LANE_W);
  assign wr_lane = in_lo[LANE_W-1:0];
  assign rd_en   = (state_q == ST_SCAN);
  assign lo_row  = ROW_W'(lo_q >> LANE_W);
  assign hi_row  = ROW_W'(hi_q >> LANE_W);

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rd_mask[k] = ((row_q != lo_row) || (LANE_W'(k) >= lo_q[LANE_W-1:0])) &&
                   ((row_q != hi_row) || (LANE_W'(k) <= hi_q[LANE_W-1:0]));
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_bank
    logic [VALUE_BITS-1:0] mem [ROWS];
    always_ff @(posedge clk_i) begin
      if (wr_en && (wr_lane == LANE_W'(k))) begin
        mem[wr_row] <= in_val;
      end
      if (rd_en) begin
        rd_data_q[k] <= mem[row_q];
      end
    end
  end

  // compare tree: level 0 qualifies lanes, each further level halves them
  logic [VALUE_BITS-1:0] node_q [TREE_LVLS+1][LANES];
  logic [LANES-1:0]      nv_q   [TREE_LVLS+1];
  logic [TREE_LVLS:0]    stv_q;

  always_ff @(posedge clk_i) begin
    rd_mask_q <= rd_mask;
    for (int k = 0; k < LANES; k++) begin
      node_q[0][k] <= rd_data_q[k];
      nv_q[0][k]   <= rd_mask_q[k] && ($signed(rd_data_q[k]) <= $signed(limit_q));
    end
    for (int l = 1; l <= TREE_LVLS; l++) begin
      for (int j = 0; j < LANES / 2; j++) begin
        if (j < (LANES >> l)) begin
          if (nv_q[l-1][2*j] && (!nv_q[l-1][2*j+1] ||
              $signed(node_q[l-1][2*j]) > $signed(node_q[l-1][2*j+1]))) begin
            node_q[l][j] <= node_q[l-1][2*j];
          end else begin
            node_q[l][j] <= node_q[l-1][2*j+1];
          end
          nv_q[l][j] <= nv_q[l-1][2*j] || nv_q[l-1][2*j+1];
        end else begin
          node_q[l][j] <= '0;
          nv_q[l][j]   <= 1'b0;
        end
      end
      for (int j = LANES / 2; j < LANES; j++) begin
        node_q[l][j] <= '0;
        nv_q[l][j]   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      stv_q  <= '0;
    end else begin
      rd_v_q <= rd_en;
      stv_q  <= {stv_q[TREE_LVLS-1:0], rd_v_q};
    end
  end

  logic merge_hit;
  logic pipe_empty;
  logic out_free;

  assign merge_hit  = stv_q[TREE_LVLS] && nv_q[TREE_LVLS][0] &&
                      (!best_found_q || ($signed(node_q[TREE_LVLS][0]) > $signed(best_q)));
  assign pipe_empty = !rd_v_q && (stv_q == '0);
  assign out_free   = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      array_length_q <= LEN_RESET;
      lo_q           <= '0;
      hi_q           <= '0;
      limit_q        <= '0;
      row_q          <= '0;
      bad_q          <= 1'b0;
      best_found_q   <= 1'b0;
      best_q         <= '0;
      out_v_q        <= 1'b0;
      out_ans_q      <= '0;
      out_bad_q      <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        array_length_q <= cfg_wr_data_i;
      end
      if (out_v_q && m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      if (merge_hit) begin
        best_found_q <= 1'b1;
        best_q       <= node_q[TREE_LVLS][0];
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (s_axis_tuser == KIND_QUERY)) begin
            lo_q         <= in_lo;
            hi_q         <= in_hi;
            limit_q      <= in_val;
            row_q        <= ROW_W'(in_lo >> LANE_W);
            bad_q        <= in_bad;
            best_found_q <= 1'b0;
            state_q      <= in_bad ? ST_DRAIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (row_q == hi_row) begin
            state_q <= ST_DRAIN;
          end else begin
            row_q <= row_q + ROW_W'(1);
          end
        end
        ST_DRAIN: begin
          if (pipe_empty && out_free) begin
            out_v_q   <= 1'b1;
            out_bad_q <= bad_q;
            out_ans_q <= best_found_q ? {best_q[VALUE_BITS-1], best_q}
                                      : {limit_q[VALUE_BITS-1], limit_q} + ANS_W'(1);
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_W'(out_ans_q);
  assign m_axis_tuser  = out_bad_q;

endmodule

`default_nettype wire

// ===== sv/rmaml_chk.sv =====
// Port-level checker for range_max_at_most_limit_top, with its bind statement.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module rmaml_chk #(
  parameter int VALUE_BITS = 32
) (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  s_axis_tvalid,
  input wire                                  s_axis_tready,
  input wire                                  s_axis_tuser,
  input wire                                  m_axis_tvalid,
  input wire                                  m_axis_tready,
  input wire [((VALUE_BITS+1+7)/8)*8-1:0]     m_axis_tdata,
  input wire                                  m_axis_tuser
);

  // a query holds the input side busy for at least the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("ready right after a query transfer");

  // a write never stalls the input side
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("not ready after a write transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind range_max_at_most_limit_top rmaml_chk #(
  .VALUE_BITS(VALUE_BITS)
) u_rmaml_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/range_query_checker.sv =====
// Checker for the range max-at-most-limit block: mirrors the element store and the length
// register, predicts each query answer and compares it with the result channel.
// Depends on rmaml_pkg.
`timescale 1ns / 1ps

module range_query_checker
  import rmaml_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_wr_en_i,
  input  logic [LEN_W-1:0]                        cfg_wr_data_i,
  input  logic                                    s_axis_tvalid,
  input  logic                                    s_axis_tready,
  input  logic [((2*IDX_W+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                    s_axis_tuser,
  input  logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  input  logic [((VALUE_BITS+1+7)/8)*8-1:0]       m_axis_tdata,
  input  logic                                    m_axis_tuser,
  output int                                      mismatch_count_o,
  output int                                      outstanding_o
);

  typedef struct packed {
    logic signed [VALUE_BITS:0] answer;
    logic                       bad_range;
  } range_answer_t;

  logic signed [VALUE_BITS-1:0] elem_store [DEPTH];
  logic [LEN_W-1:0]             array_len;
  range_answer_t                pending_answers [$];
  int                           mismatches;

  assign mismatch_count_o = mismatches;

  function automatic range_answer_t max_at_most(input logic [IDX_W-1:0] lo,
                                                input logic [IDX_W-1:0] hi,
                                                input logic signed [VALUE_BITS-1:0] limit);
    range_answer_t                r;
    int                           span_len;
    logic signed [VALUE_BITS-1:0] best;
    bit                           found;
    span_len    = (array_len > DEPTH) ? DEPTH : int'(array_len);
    r.bad_range = (lo > hi) || (hi >= span_len);
    found       = 1'b0;
    best        = '0;
    if (!r.bad_range) begin
      for (int i = lo; i <= hi; i++) begin
        if (elem_store[i] <= limit && (!found || elem_store[i] > best)) begin
          best  = elem_store[i];
          found = 1'b1;
        end
      end
    end
    // no qualifying element (or bad range): limit plus one, one bit wider
    r.answer = found ? {best[VALUE_BITS-1], best} : {limit[VALUE_BITS-1], limit} + 1'b1;
    return r;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [IDX_W-1:0]             lo;
    logic [IDX_W-1:0]             hi;
    logic signed [VALUE_BITS-1:0] val;
    logic signed [VALUE_BITS:0]   got_answer;
    range_answer_t                exp;
    if (!rst_ni) begin
      array_len = LEN_RESET;
      pending_answers.delete();
      mismatches = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_wr_en_i) begin
        array_len = cfg_wr_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        lo  = s_axis_tdata[IDX_W-1:0];
        hi  = s_axis_tdata[2*IDX_W-1:IDX_W];
        val = s_axis_tdata[2*IDX_W +: VALUE_BITS];
        if (s_axis_tuser == KIND_WRITE) begin
          if (lo < DEPTH) begin
            elem_store[lo] = val;
          end
        end else begin
          pending_answers.push_back(max_at_most(lo, hi, val));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_answer = m_axis_tdata[VALUE_BITS:0];
        if (pending_answers.size() == 0) begin
          flag($sformatf("unexpected result answer=%0d bad_range=%0b",
                         got_answer, m_axis_tuser));
        end else begin
          exp = pending_answers.pop_front();
          if (exp.answer !== got_answer) begin
            flag($sformatf("answer expected %0d got %0d", exp.answer, got_answer));
          end
          if (exp.bad_range !== m_axis_tuser) begin
            flag($sformatf("bad_range expected %0b got %0b", exp.bad_range, m_axis_tuser));
          end
        end
      end
      outstanding_o <= pending_answers.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for range_max_at_most_limit_top: drives writes, range queries and length
// settings with random idling and a long output hold-off. Depends on rmaml_pkg, the block
// and range_query_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_top;
  import rmaml_pkg::*;

  localparam int DEPTH         = 1024;
  localparam int VALUE_BITS    = 32;
  localparam int S_W           = ((2*IDX_W+VALUE_BITS+7)/8)*8;
  localparam int M_W           = ((VALUE_BITS+1+7)/8)*8;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_ITEMS   = 530;
  localparam int HOLD_AFTER    = 150;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [VALUE_BITS-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_BITS-1:0] VAL_MIN = 32'h8000_0000;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_wr_en_i   = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic [S_W-1:0]   s_axis_tdata  = '0;
  logic             s_axis_tuser  = 1'b0;
  logic             m_axis_tready = 1'b0;
  wire              s_axis_tready;
  wire              m_axis_tvalid;
  wire  [M_W-1:0]   m_axis_tdata;
  wire              m_axis_tuser;

  int mismatch_count;
  int outstanding;
  int tx_idle_pct = 25;
  int rx_idle_pct = 50;
  int eff_len     = DEPTH;
  int fill_ptr    = 4;

  bit                    written [DEPTH];
  logic [VALUE_BITS-1:0] shadow  [DEPTH];

  range_max_at_most_limit_top #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  range_query_checker #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random ready, plus one long hold-off so the block backs up
  initial begin : receiver
    int  got;
    bit  held;
    got  = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got++;
      end
      if (!held && got >= HOLD_AFTER) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(input logic kind, input logic [IDX_W-1:0] lo,
                           input logic [IDX_W-1:0] hi, input logic [VALUE_BITS-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(S_W-2*IDX_W-VALUE_BITS){1'b0}}, value, hi, lo};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_element(input logic [IDX_W-1:0] idx, input logic [VALUE_BITS-1:0] value);
    written[idx] = 1'b1;
    shadow[idx]  = value;
    send_item(KIND_WRITE, idx, IDX_W'($urandom), value);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_length(input int len);
    drain();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= LEN_W'(len);
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    eff_len = (len > DEPTH) ? DEPTH : len;
  endtask

  function automatic logic [VALUE_BITS-1:0] random_element();
    case ($urandom_range(19))
      0:             return VAL_MAX;
      1:             return VAL_MIN;
      2:             return '0;
      3:             return '1;
      4, 5, 6, 7, 8: return $urandom;
      default:       return VALUE_BITS'($urandom_range(200)) - VALUE_BITS'(100);
    endcase
  endfunction

  // finds a range inside the length in use that covers written entries only
  task automatic pick_written_span(output logic [IDX_W-1:0] lo, output logic [IDX_W-1:0] hi,
                                   output bit ok);
    int w;
    int reach;
    int a;
    int b;
    ok = 1'b0;
    lo = '0;
    hi = '0;
    for (int tries = 0; tries < 8 && !ok && eff_len > 0; tries++) begin
      w = $urandom_range(eff_len-1, 0);
      if (written[w]) begin
        reach = ($urandom_range(9) == 0) ? DEPTH : $urandom_range(40);
        a = w;
        while (a > 0 && written[a-1] && w - a < reach) a--;
        b = w;
        while (b < eff_len-1 && written[b+1] && b - w < reach) b++;
        lo = IDX_W'(a);
        hi = IDX_W'(b);
        ok = 1'b1;
      end
    end
  endtask

  task automatic random_item();
    int                    pick;
    int                    j;
    logic [IDX_W-1:0]      lo;
    logic [IDX_W-1:0]      hi;
    logic [VALUE_BITS-1:0] limit;
    bit                    ok;
    pick = $urandom_range(99);
    if (pick < 45) begin
      if ($urandom_range(3) != 0) begin
        lo       = fill_ptr[IDX_W-1:0];
        fill_ptr = (fill_ptr + 1) % DEPTH;
      end else begin
        lo = IDX_W'($urandom_range(DEPTH-1));
      end
      write_element(lo, random_element());
    end else begin
      ok = 1'b0;
      if (pick < 85) begin
        pick_written_span(lo, hi, ok);
      end
      if (ok) begin
        j = $urandom_range(hi, lo);
        case ($urandom_range(9))
          0, 1, 2, 3: limit = shadow[j];
          4:          limit = shadow[j] + 1'b1;
          5:          limit = shadow[j] - 1'b1;
          6, 7:       limit = random_element();
          8:          limit = VAL_MAX;
          default:    limit = VAL_MIN;
        endcase
        send_item(KIND_QUERY, lo, hi, limit);
      end else begin
        if (eff_len < DEPTH && $urandom_range(1) == 1) begin
          hi = IDX_W'($urandom_range(DEPTH-1, eff_len));
          lo = IDX_W'($urandom);
        end else begin
          lo = IDX_W'($urandom_range(DEPTH-1, 1));
          hi = IDX_W'($urandom_range(lo-1, 0));
        end
        send_item(KIND_QUERY, lo, hi, random_element());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_length(DEPTH);
    write_element(IDX_W'(0), 32'd5);
    write_element(IDX_W'(1), VAL_MIN);
    write_element(IDX_W'(2), VAL_MAX);
    write_element(IDX_W'(3), '1);
    write_element(IDX_W'(1022), '0);
    write_element(IDX_W'(1023), -32'sd7);
    send_item(KIND_QUERY, IDX_W'(0), IDX_W'(0), 32'd5);
    send_item(KIND_QUERY, IDX_W'(0), IDX_W'(0), 32'd4);       // nothing qualifies
    send_item(KIND_QUERY, IDX_W'(0), IDX_W'(3), VAL_MAX);
    send_item(KIND_QUERY, IDX_W'(0), IDX_W'(3), VAL_MIN);
    send_item(KIND_QUERY, IDX_W'(0), IDX_W'(3), -32'sd2);
    send_item(KIND_QUERY, IDX_W'(0), IDX_W'(3), '0);
    send_item(KIND_QUERY, IDX_W'(2), IDX_W'(2), VAL_MIN);
    send_item(KIND_QUERY, IDX_W'(5), IDX_W'(3), VAL_MAX);     // lo above hi, answer needs the extra bit
    send_item(KIND_QUERY, IDX_W'(1022), IDX_W'(1023), -32'sd8);

    set_length(0);                            // every query out of range
    send_item(KIND_QUERY, IDX_W'(0), IDX_W'(0), 32'd1);
    send_item(KIND_QUERY, IDX_W'(0), IDX_W'(0), VAL_MIN);

    set_length(1);
    send_item(KIND_QUERY, IDX_W'(0), IDX_W'(0), 32'd10);
    send_item(KIND_QUERY, IDX_W'(0), IDX_W'(1), 32'd10);

    set_length(2047);                         // saturates to the full store
    send_item(KIND_QUERY, IDX_W'(1023), IDX_W'(1023), VAL_MAX);
    send_item(KIND_QUERY, IDX_W'(1022), IDX_W'(1023), VAL_MAX);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 25;
          rx_idle_pct = 50;
          set_length(DEPTH);
        end
        1: begin
          tx_idle_pct = 50;
          rx_idle_pct = 25;
          set_length($urandom_range(DEPTH-1, 200));
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          set_length(2047);
        end
      endcase
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rmaml_pkg.sv
sv/range_max_at_most_limit_top.sv
sv/rmaml_chk.sv
verif/range_query_checker.sv
verif/tb_top.sv
